[rtl/core/uxf_pkg.sv]
// ----------------------------------------------------------------------------
// uxf_pkg: shared definitions for the serial ring buffer block
// Ring sizes, control characters, opcodes and the packed result item.
// ----------------------------------------------------------------------------
package uxf_pkg;

	localparam int RX_DEPTH = 64;
	// transmit ring is split into even and odd banks, so its depth stays even
	localparam int TX_DEPTH = 64;

	localparam int RX_AW  = $clog2(RX_DEPTH);
	localparam int RX_CW  = $clog2(RX_DEPTH + 1);
	localparam int TX_AW  = $clog2(TX_DEPTH);
	localparam int TX_UW  = TX_AW + 1;
	localparam int TX_BAW = TX_AW - 1;
	localparam int MARK_W = 5;
	localparam int SUM_W  = ((RX_CW > MARK_W) ? RX_CW : MARK_W) + 1;

	localparam logic [7:0] CH_XON  = 8'h11;
	localparam logic [7:0] CH_XOFF = 8'h13;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;

	localparam logic [MARK_W-1:0] FLOW_MARK_RESET = 5'd5;

	localparam logic CFG_FLOW_MARK      = 1'b0;
	localparam logic CFG_NEWLINE_EXPAND = 1'b1;

	typedef enum logic [2:0] {
		OP_RX_BYTE    = 3'd0,
		OP_TX_READY   = 3'd1,
		OP_HOST_READ  = 3'd2,
		OP_HOST_WRITE = 3'd3,
		OP_SET_FLOW   = 3'd4
	} opcode_t;

	typedef struct packed {
		logic       rx_overflow;
		logic       write_rejected;
		logic       flow_enabled;
		logic       tx_empty;
		logic       tx_full;
		logic       rx_available;
		logic [7:0] read_byte;
		logic       read_valid;
		logic [7:0] tx_byte;
		logic       tx_valid;
	} out_item_t;

	function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] i);
		return (i == RX_AW'(RX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] i);
		return (i == TX_AW'(TX_DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

[rtl/core/uxf_ram.sv]
// ----------------------------------------------------------------------------
// uxf_ram: simple dual-port byte RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module uxf_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/uart_fifo_xon_xoff_flow_top.sv]
// ----------------------------------------------------------------------------
// uart_fifo_xon_xoff_flow_top: serial link ring buffers with XON/XOFF
// Receive and transmit rings, control character queueing, newline expansion.
// ----------------------------------------------------------------------------
// Path: an accepted input is held in the input register, then in the result
// register that drives m_tdata.
// Throughput: 1 item per cycle unless m_tready stalls the result register;
// each item does one pass over the ring pointers and one access per ring RAM port.
// Reset: arst_n clears pointers, counts, pending control and valids; flow on,
// flow_mark 5, newline expansion on. Ring RAM contents are not cleared.
// ----------------------------------------------------------------------------
module uart_fifo_xon_xoff_flow_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // data_byte[7:0], flow_on[8], zero[15:9]
	input  logic [2:0]  s_tuser,   // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // tx_valid, tx_byte, read_valid, read_byte,
	                               // rx_available, tx_full, tx_empty,
	                               // flow_enabled, write_rejected, rx_overflow
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [4:0]  cfg_wdata
);

	localparam int RX_AW  = uxf_pkg::RX_AW;
	localparam int RX_CW  = uxf_pkg::RX_CW;
	localparam int TX_AW  = uxf_pkg::TX_AW;
	localparam int TX_UW  = uxf_pkg::TX_UW;
	localparam int TX_BAW = uxf_pkg::TX_BAW;
	localparam int SUM_W  = uxf_pkg::SUM_W;

	// configuration
	logic [uxf_pkg::MARK_W-1:0] flow_mark_q;
	logic                       newline_expand_q;

	// ring state
	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d;
	logic [RX_CW-1:0] rx_count_q, rx_count_d;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d;
	logic [7:0]       pending_q, pending_d;
	logic             flow_q, flow_d;

	// pipeline
	logic              valid_s1, valid_s2;
	uxf_pkg::opcode_t  opcode_s1;
	logic [7:0]        data_s1;
	logic              flow_on_s1;
	logic              s2_load, adv;

	logic       txv_s2, tx_ctrl_s2, tx_bank_s2, rdv_s2;
	logic [7:0] ctrl_s2;
	logic       rx_avail_s2, tx_full_s2, tx_empty_s2, flow_en_s2, wrej_s2, rovf_s2;

	// step results
	logic       txv, tx_ctrl, rdv, wrej, rovf;
	logic       rx_we, push1, push2;
	logic [TX_UW-1:0] tx_used;
	logic [TX_AW-1:0] tx_tail_n1;
	logic [7:0]       first_byte;

	// RAM ports
	logic [7:0]        rx_rdata, txe_rdata, txo_rdata;
	logic              txe_we, txo_we;
	logic [TX_BAW-1:0] txe_waddr, txo_waddr;
	logic [7:0]        txe_wdata, txo_wdata;

	uxf_pkg::out_item_t out_item;

	assign s2_load  = !valid_s2 || m_tready;
	assign adv      = valid_s1 && s2_load;
	assign s_tready = !valid_s1 || s2_load;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_mark_q      <= uxf_pkg::FLOW_MARK_RESET;
			newline_expand_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_addr)
				uxf_pkg::CFG_FLOW_MARK:      flow_mark_q      <= cfg_wdata;
				uxf_pkg::CFG_NEWLINE_EXPAND: newline_expand_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (s2_load) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1  <= uxf_pkg::opcode_t'(s_tuser);
			data_s1    <= s_tdata[7:0];
			flow_on_s1 <= s_tdata[8];
		end
	end

	always_comb begin
		tx_used = {1'b0, tx_tail_q} - {1'b0, tx_head_q};
		if (tx_tail_q < tx_head_q) begin
			tx_used = tx_used + TX_UW'(uxf_pkg::TX_DEPTH);
		end
	end

	assign tx_tail_n1 = uxf_pkg::tx_next(tx_tail_q);

	always_comb begin
		rx_head_d  = rx_head_q;
		rx_tail_d  = rx_tail_q;
		rx_count_d = rx_count_q;
		tx_head_d  = tx_head_q;
		tx_tail_d  = tx_tail_q;
		pending_d  = pending_q;
		flow_d     = flow_q;
		txv        = 1'b0;
		tx_ctrl    = 1'b0;
		rdv        = 1'b0;
		wrej       = 1'b0;
		rovf       = 1'b0;
		rx_we      = 1'b0;
		push1      = 1'b0;
		push2      = 1'b0;
		case (opcode_s1)
			uxf_pkg::OP_RX_BYTE: begin
				if (rx_count_q == RX_CW'(uxf_pkg::RX_DEPTH)) begin
					rovf = 1'b1;
				end else begin
					rx_we      = 1'b1;
					rx_tail_d  = uxf_pkg::rx_next(rx_tail_q);
					rx_count_d = rx_count_q + 1'b1;
				end
				if (flow_q && (SUM_W'(rx_count_d) + SUM_W'(flow_mark_q)
						>= SUM_W'(uxf_pkg::RX_DEPTH))) begin
					pending_d = uxf_pkg::CH_XOFF;
					flow_d    = 1'b0;
				end
			end
			uxf_pkg::OP_TX_READY: begin
				if (pending_q != 8'h00) begin
					txv       = 1'b1;
					tx_ctrl   = 1'b1;
					pending_d = 8'h00;
				end else if (tx_head_q != tx_tail_q) begin
					txv       = 1'b1;
					tx_head_d = uxf_pkg::tx_next(tx_head_q);
				end
			end
			uxf_pkg::OP_HOST_READ: begin
				if (rx_count_q != '0) begin
					rdv        = 1'b1;
					rx_head_d  = uxf_pkg::rx_next(rx_head_q);
					rx_count_d = rx_count_q - 1'b1;
				end
				if (!flow_q && (SUM_W'(rx_count_d) <= SUM_W'(flow_mark_q))) begin
					pending_d = uxf_pkg::CH_XON;
					flow_d    = 1'b1;
				end
			end
			uxf_pkg::OP_HOST_WRITE: begin
				if (data_s1 == uxf_pkg::CH_LF && newline_expand_q) begin
					if (tx_used <= TX_UW'(uxf_pkg::TX_DEPTH - 3)) begin
						push2     = 1'b1;
						tx_tail_d = uxf_pkg::tx_next(tx_tail_n1);
					end else begin
						wrej = 1'b1;
					end
				end else if (tx_used <= TX_UW'(uxf_pkg::TX_DEPTH - 2)) begin
					push1     = 1'b1;
					tx_tail_d = tx_tail_n1;
				end else begin
					wrej = 1'b1;
				end
			end
			uxf_pkg::OP_SET_FLOW: begin
				if (flow_q != flow_on_s1) begin
					pending_d = flow_on_s1 ? uxf_pkg::CH_XON : uxf_pkg::CH_XOFF;
					flow_d    = flow_on_s1;
				end
			end
			default: ;
		endcase
	end

	// CR and LF land at consecutive indexes, one in each bank
	assign first_byte = push2 ? uxf_pkg::CH_CR : data_s1;

	always_comb begin
		txe_we    = 1'b0;
		txo_we    = 1'b0;
		txe_waddr = tx_tail_q[TX_AW-1:1];
		txo_waddr = tx_tail_q[TX_AW-1:1];
		txe_wdata = first_byte;
		txo_wdata = first_byte;
		if (!tx_tail_q[0]) begin
			txe_we    = adv && (push1 || push2);
			txo_we    = adv && push2;
			txo_waddr = tx_tail_n1[TX_AW-1:1];
			txo_wdata = uxf_pkg::CH_LF;
		end else begin
			txo_we    = adv && (push1 || push2);
			txe_we    = adv && push2;
			txe_waddr = tx_tail_n1[TX_AW-1:1];
			txe_wdata = uxf_pkg::CH_LF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			rx_count_q <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			pending_q  <= 8'h00;
			flow_q     <= 1'b1;
		end else if (adv) begin
			rx_head_q  <= rx_head_d;
			rx_tail_q  <= rx_tail_d;
			rx_count_q <= rx_count_d;
			tx_head_q  <= tx_head_d;
			tx_tail_q  <= tx_tail_d;
			pending_q  <= pending_d;
			flow_q     <= flow_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			txv_s2      <= txv;
			tx_ctrl_s2  <= tx_ctrl;
			ctrl_s2     <= pending_q;
			tx_bank_s2  <= tx_head_q[0];
			rdv_s2      <= rdv;
			rx_avail_s2 <= (rx_count_d != '0);
			tx_full_s2  <= (uxf_pkg::tx_next(tx_tail_d) == tx_head_d);
			tx_empty_s2 <= (tx_head_d == tx_tail_d);
			flow_en_s2  <= flow_d;
			wrej_s2     <= wrej;
			rovf_s2     <= rovf;
		end
	end

	uxf_ram #(.DEPTH(uxf_pkg::RX_DEPTH), .AW(RX_AW)) u_rx_ram (
		.clk   (clk),
		.we    (adv && rx_we),
		.waddr (rx_tail_q),
		.wdata (data_s1),
		.re    (adv),
		.raddr (rx_head_q),
		.rdata (rx_rdata)
	);

	uxf_ram #(.DEPTH(uxf_pkg::TX_DEPTH / 2), .AW(TX_BAW)) u_tx_even_ram (
		.clk   (clk),
		.we    (txe_we),
		.waddr (txe_waddr),
		.wdata (txe_wdata),
		.re    (adv),
		.raddr (tx_head_q[TX_AW-1:1]),
		.rdata (txe_rdata)
	);

	uxf_ram #(.DEPTH(uxf_pkg::TX_DEPTH / 2), .AW(TX_BAW)) u_tx_odd_ram (
		.clk   (clk),
		.we    (txo_we),
		.waddr (txo_waddr),
		.wdata (txo_wdata),
		.re    (adv),
		.raddr (tx_head_q[TX_AW-1:1]),
		.rdata (txo_rdata)
	);

	always_comb begin
		out_item.tx_valid       = txv_s2;
		out_item.tx_byte        = !txv_s2 ? 8'h00 :
		                          tx_ctrl_s2 ? ctrl_s2 :
		                          tx_bank_s2 ? txo_rdata : txe_rdata;
		out_item.read_valid     = rdv_s2;
		out_item.read_byte      = rdv_s2 ? rx_rdata : 8'h00;
		out_item.rx_available   = rx_avail_s2;
		out_item.tx_full        = tx_full_s2;
		out_item.tx_empty       = tx_empty_s2;
		out_item.flow_enabled   = flow_en_s2;
		out_item.write_rejected = wrej_s2;
		out_item.rx_overflow    = rovf_s2;
	end

	assign m_tdata = out_item;

	a_rx_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rx_count_q <= RX_CW'(uxf_pkg::RX_DEPTH))
		else $error("receive count above ring depth");

	a_rx_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_count_q == '0) |-> (rx_head_q == rx_tail_q))
		else $error("empty receive ring with unequal pointers");

	a_rx_full_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(rx_count_q == RX_CW'(uxf_pkg::RX_DEPTH)) |-> (rx_head_q == rx_tail_q))
		else $error("full receive ring with unequal pointers");

	a_tx_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(tx_full_s2 && tx_empty_s2))
		else $error("transmit ring reported full and empty");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && !m_tready))
		else $error("input stalled with room in the pipeline");

endmodule
